FILE: rtl/core/ccg_pkg.sv
package ccg_pkg;

  localparam int MAX_DIM = 4096;

  localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [31:0] HALF_Q31 = 32'h8000_0000;
  localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;

  localparam logic [2:0] REG_GRID_WIDTH      = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_LAYER_THICKNESS = 3'd2;
  localparam logic [2:0] REG_SIGMA_PEAK      = 3'd3;
  localparam logic [2:0] REG_KAPPA_PEAK      = 3'd4;
  localparam logic [2:0] REG_ALPHA_PEAK      = 3'd5;
  localparam logic [2:0] REG_TIME_STEP       = 3'd6;

endpackage

FILE: rtl/core/ccg_div_pipe.sv
module ccg_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] dividend_bits,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side,
  output logic          quo_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] quo_side
);

  // one restoring step per stage; rem_init must be below divisor
  logic          v    [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] bits [0:QW];
  logic [DW-1:0] dsr  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [SW-1:0] sd   [0:QW];

  assign v[0]    = valid;
  assign rem[0]  = rem_init;
  assign bits[0] = dividend_bits;
  assign dsr[0]  = divisor;
  assign q[0]    = '0;
  assign sd[0]   = side;

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW:0] trial;
    logic        take;

    assign trial = {rem[s], bits[s][QW-1]};
    assign take  = trial >= {1'b0, dsr[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= take ? DW'(trial - {1'b0, dsr[s]}) : trial[DW-1:0];
        bits[s+1] <= bits[s] << 1;
        dsr[s+1]  <= dsr[s];
        q[s+1]    <= {q[s][QW-2:0], take};
        sd[s+1]   <= sd[s];
      end
    end
  end

  assign quo_valid = v[QW];
  assign quo       = q[QW];
  assign quo_side  = sd[QW];

endmodule

FILE: rtl/core/ccg_exp_pipe.sv
module ccg_exp_pipe
  import ccg_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid,
  input  logic [48:0]   x,
  input  logic [SW-1:0] side,
  output logic          b_valid,
  output logic [31:0]   b,
  output logic [SW-1:0] b_side
);

  localparam int KS = 5;   // bits of k
  localparam int NT = 15;  // series terms 2..16

  typedef struct packed {
    logic [SW-1:0] side;
    logic          over;
    logic [4:0]    k;
    logic [31:0]   r;
    logic [33:0]   pos;
    logic [33:0]   neg;
  } ctx_t;

  // range reduction: k = x / ln2, r = x - k*ln2, one bit of k per stage
  logic          kv    [0:KS];
  logic [48:0]   krem  [0:KS];
  logic [4:0]    kk    [0:KS];
  logic          kover [0:KS];
  logic [SW-1:0] kside [0:KS];

  localparam logic [48:0] LIMIT = 49'(LN2_Q32) << KS;

  assign kv[0]    = valid;
  assign krem[0]  = x;
  assign kk[0]    = '0;
  assign kover[0] = x >= LIMIT;
  assign kside[0] = side;

  for (genvar j = 0; j < KS; j++) begin : g_k
    localparam logic [48:0] STEP = 49'(LN2_Q32) << (KS - 1 - j);
    logic take;

    assign take = krem[j] >= STEP;

    always_ff @(posedge clk) begin
      if (rst) begin
        kv[j+1] <= 1'b0;
      end else if (en) begin
        kv[j+1] <= kv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        krem[j+1]  <= take ? krem[j] - STEP : krem[j];
        kk[j+1]    <= {kk[j][3:0], take};
        kover[j+1] <= kover[j];
        kside[j+1] <= kside[j];
      end
    end
  end

  // Taylor series, three stages per term
  logic        tv [0:NT];
  ctx_t        tc [0:NT];
  logic [31:0] tt [0:NT];

  assign tv[0] = kv[KS];
  assign tt[0] = krem[KS][31:0];
  assign tc[0] = '{side: kside[KS], over: kover[KS], k: kk[KS], r: krem[KS][31:0],
                   pos: 34'h1_0000_0000, neg: {2'b00, krem[KS][31:0]}};

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int          M     = i + 2;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / M);

    logic        av, bv;
    ctx_t        ac, bc, nc;
    logic [31:0] ay, by, bq;
    logic [63:0] aprod, bprod;
    logic [31:0] qm, rem, qf;

    assign aprod = 64'(tt[i]) * 64'(tc[i].r);
    assign bprod = 64'(ay) * 64'(RECIP);

    // reciprocal estimate is low by at most one
    always_comb begin
      qm = 32'(36'(bq) * 36'(M));
      rem = by - qm;
      qf = (rem >= 32'(M)) ? bq + 32'd1 : bq;
      nc = bc;
      if (M % 2 == 1) begin
        nc.neg = bc.neg + 34'(qf);
      end else begin
        nc.pos = bc.pos + 34'(qf);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        av      <= 1'b0;
        bv      <= 1'b0;
        tv[i+1] <= 1'b0;
      end else if (en) begin
        av      <= tv[i];
        bv      <= av;
        tv[i+1] <= bv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ac      <= tc[i];
        ay      <= aprod[63:32];
        bc      <= ac;
        by      <= ay;
        bq      <= bprod[63:32];
        tc[i+1] <= nc;
        tt[i+1] <= qf;
      end
    end
  end

  logic [33:0] e;
  logic [32:0] ecap;
  logic [5:0]  sh;
  logic [32:0] shifted;

  always_comb begin
    e = tc[NT].pos - tc[NT].neg;
    ecap = (e > 34'h1_0000_0000) ? 33'h1_0000_0000 : e[32:0];
    sh = {1'b0, tc[NT].k} + 6'd1;
    shifted = ecap >> sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= tv[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b      <= tc[NT].over ? 32'd0 : shifted[31:0];
      b_side <= tc[NT].side;
    end
  end

endmodule

FILE: rtl/core/cpml_coefficient_generator_unit.sv
// Throughput: one item per cycle unless a stalled result holds the pipeline; each step
// of the four long dividers and of the exp range reduction is its own register stage,
// and every series term has its own register stages.
// A stalled result holds the whole pipeline in place.
// Reset (synchronous, rst high) clears all valid bits and loads register defaults.
module cpml_coefficient_generator_unit
  import ccg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               axis,
  input  logic [11:0]        cell_index,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        kappa_value,
  output logic [31:0]        decay_coef,
  output logic signed [31:0] conv_coef,
  output logic               index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef struct packed {
    logic err;
    logic zero;
    logic full;
  } pdiv_side_t;

  typedef struct packed {
    logic        err;
    logic        signz;
    logic        ufull;
    logic [31:0] sigma;
    logic [31:0] alpha;
    logic [31:0] kappa;
    logic [48:0] s;
  } qdiv_side_t;

  typedef struct packed {
    logic        err;
    logic        signz;
    logic        ufull;
    logic [31:0] kappa;
    logic [48:0] q;
  } udiv_side_t;

  typedef struct packed {
    logic        err;
    logic        signz;
    logic        ufull;
    logic [31:0] kappa;
    logic [31:0] u;
  } exp_side_t;

  typedef struct packed {
    logic        err;
    logic        signz;
    logic [31:0] b;
    logic [31:0] kappa;
  } mdiv_side_t;

  logic [12:0] grid_width, grid_height, layer_thickness;
  logic [31:0] sigma_peak, kappa_peak, alpha_peak, time_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= 13'd256;
      grid_height     <= 13'd256;
      layer_thickness <= 13'd10;
      sigma_peak      <= 32'd65536;
      kappa_peak      <= 32'd65536;
      alpha_peak      <= 32'd0;
      time_step       <= 32'h8000_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:      grid_width      <= cfg_data[12:0];
        REG_GRID_HEIGHT:     grid_height     <= cfg_data[12:0];
        REG_LAYER_THICKNESS: layer_thickness <= cfg_data[12:0];
        REG_SIGMA_PEAK:      sigma_peak      <= cfg_data;
        REG_KAPPA_PEAK:      kappa_peak      <= cfg_data;
        REG_ALPHA_PEAK:      alpha_peak      <= cfg_data;
        REG_TIME_STEP:       time_step       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // stage A: edge position
  logic [12:0] n_raw, n, idx13, num;
  logic [13:0] sum14;
  logic        err_in;

  always_comb begin
    n_raw = axis ? grid_height : grid_width;
    n = (17'(n_raw) > 17'(MAX_DIM)) ? 13'(MAX_DIM) : n_raw;
    idx13 = {1'b0, cell_index};
    err_in = idx13 >= n;
    sum14 = 14'(idx13) + 14'(layer_thickness);
    if (idx13 < layer_thickness) begin
      num = layer_thickness - idx13;
    end else if (sum14 >= 14'(n)) begin
      num = 13'(sum14 + 14'd1 - 14'(n));
    end else begin
      num = '0;
    end
  end

  logic        a_v, b_v, c_v;
  logic        a_err, b_err, c_err;
  logic [12:0] a_num, b_num;
  logic [25:0] b_nsq, b_tsq;
  logic [38:0] c_ncu, c_tcu;
  logic        c_zero, c_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (adv) begin
      a_v <= item_valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_err  <= err_in;
      a_num  <= num;
      b_err  <= a_err;
      b_num  <= a_num;
      b_nsq  <= 26'(a_num) * 26'(a_num);
      b_tsq  <= 26'(layer_thickness) * 26'(layer_thickness);
      c_err  <= b_err;
      c_ncu  <= 39'(b_nsq) * 39'(b_num);
      c_tcu  <= 39'(b_tsq) * 39'(layer_thickness);
      c_zero <= b_num == 13'd0;
      c_full <= b_num == layer_thickness;
    end
  end

  // p = num^3 / t^3 as Q0.32
  pdiv_side_t pd_in, pd_out;
  logic       p_v;
  logic [31:0] p_q;

  assign pd_in = '{err: c_err, zero: c_zero, full: c_full};

  ccg_div_pipe #(.DW(39), .QW(32), .SW($bits(pdiv_side_t))) u_pdiv (
    .clk(clk), .rst(rst), .en(adv), .valid(c_v),
    .rem_init(c_ncu), .dividend_bits(32'd0), .divisor(c_tcu), .side(pd_in),
    .quo_valid(p_v), .quo(p_q), .quo_side(pd_out)
  );

  // stage D: grade the peaks
  logic [31:0] kpm1;
  logic [63:0] sprod, aprod, kprod;
  logic        d_v, e_v, f_v, g_v;
  logic        d_err, e_err, f_err, g_err;
  logic [31:0] d_sigma, d_alpha, d_kdel;
  logic [31:0] e_sigma, e_alpha, e_kappa;
  logic [31:0] f_sigma, f_alpha, f_kappa;
  logic [47:0] f_ak;
  logic [63:0] akprod;
  logic [31:0] g_sigma, g_alpha, g_kappa;
  logic [48:0] g_s;
  logic        g_ufull, g_signz;

  assign kpm1   = (kappa_peak < ONE_Q16) ? 32'd0 : kappa_peak - ONE_Q16;
  assign sprod  = 64'(sigma_peak) * 64'(p_q);
  assign aprod  = 64'(alpha_peak) * 64'(p_q);
  assign kprod  = 64'(kpm1) * 64'(p_q);
  assign akprod = 64'(e_alpha) * 64'(e_kappa);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (adv) begin
      d_v <= p_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_err   <= pd_out.err;
      d_sigma <= pd_out.zero ? 32'd0 : (pd_out.full ? sigma_peak : sprod[63:32]);
      d_alpha <= pd_out.zero ? 32'd0 : (pd_out.full ? alpha_peak : aprod[63:32]);
      d_kdel  <= pd_out.zero ? 32'd0 : (pd_out.full ? kpm1 : kprod[63:32]);
      e_err   <= d_err;
      e_sigma <= d_sigma;
      e_alpha <= d_alpha;
      e_kappa <= ONE_Q16 + d_kdel;
      f_err   <= e_err;
      f_sigma <= e_sigma;
      f_alpha <= e_alpha;
      f_kappa <= e_kappa;
      f_ak    <= akprod[63:16];
      g_err   <= f_err;
      g_sigma <= f_sigma;
      g_alpha <= f_alpha;
      g_kappa <= f_kappa;
      g_s     <= 49'(f_sigma) + 49'(f_ak);
      g_ufull <= f_ak == 48'd0;
      g_signz <= f_sigma != 32'd0;
    end
  end

  // sigma / kappa as Q16.32
  qdiv_side_t qd_in, qd_out;
  logic       q_v;
  logic [47:0] q_q;

  assign qd_in = '{err: g_err, signz: g_signz, ufull: g_ufull, sigma: g_sigma,
                   alpha: g_alpha, kappa: g_kappa, s: g_s};

  ccg_div_pipe #(.DW(32), .QW(48), .SW($bits(qdiv_side_t))) u_qdiv (
    .clk(clk), .rst(rst), .en(adv), .valid(g_v),
    .rem_init({16'd0, g_sigma[31:16]}), .dividend_bits({g_sigma[15:0], 32'd0}),
    .divisor(g_kappa), .side(qd_in),
    .quo_valid(q_v), .quo(q_q), .quo_side(qd_out)
  );

  // u = sigma / (sigma + alpha*kappa) as Q0.32
  udiv_side_t ud_in, ud_out;
  logic       u_v;
  logic [31:0] u_q;

  assign ud_in = '{err: qd_out.err, signz: qd_out.signz, ufull: qd_out.ufull,
                   kappa: qd_out.kappa,
                   q: 49'(q_q) + {1'b0, qd_out.alpha, 16'd0}};

  ccg_div_pipe #(.DW(49), .QW(32), .SW($bits(udiv_side_t))) u_udiv (
    .clk(clk), .rst(rst), .en(adv), .valid(q_v),
    .rem_init(49'(qd_out.sigma)), .dividend_bits(32'd0), .divisor(qd_out.s), .side(ud_in),
    .quo_valid(u_v), .quo(u_q), .quo_side(ud_out)
  );

  // stages I, J: x = q * dt
  logic [48:0] hprod;
  logic [63:0] lprod;
  logic        i_v, j_v;
  logic [48:0] i_hx, j_x;
  logic [31:0] i_lx;
  exp_side_t   i_side, j_side;

  assign hprod = 49'(ud_out.q[48:32]) * 49'(time_step);
  assign lprod = 64'(ud_out.q[31:0]) * 64'(time_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
      j_v <= 1'b0;
    end else if (adv) begin
      i_v <= u_v;
      j_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_hx   <= hprod;
      i_lx   <= lprod[63:32];
      i_side <= '{err: ud_out.err, signz: ud_out.signz, ufull: ud_out.ufull,
                  kappa: ud_out.kappa, u: u_q};
      j_x    <= i_hx + 49'(i_lx);
      j_side <= i_side;
    end
  end

  logic        x_v;
  logic [31:0] x_b;
  exp_side_t   x_side;

  ccg_exp_pipe #(.SW($bits(exp_side_t))) u_exp (
    .clk(clk), .rst(rst), .en(adv), .valid(j_v), .x(j_x), .side(j_side),
    .b_valid(x_v), .b(x_b), .b_side(x_side)
  );

  // stage K: w = u * (1 - b)
  logic [31:0] wn, wsel;
  logic [63:0] wprod;
  logic        k_v;
  logic [31:0] k_w;
  mdiv_side_t  k_side;

  assign wn    = HALF_Q31 - x_b;
  assign wprod = 64'(x_side.u) * 64'(wn);
  assign wsel  = x_side.ufull ? wn : wprod[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (adv) begin
      k_v <= x_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_w    <= wsel;
      k_side <= '{err: x_side.err, signz: x_side.signz, b: x_b, kappa: x_side.kappa};
    end
  end

  // m = w / kappa
  logic        m_v;
  logic [31:0] m_q;
  mdiv_side_t  m_side;

  ccg_div_pipe #(.DW(32), .QW(32), .SW($bits(mdiv_side_t))) u_mdiv (
    .clk(clk), .rst(rst), .en(adv), .valid(k_v),
    .rem_init({16'd0, k_w[31:16]}), .dividend_bits({k_w[15:0], 16'd0}),
    .divisor(k_side.kappa), .side(k_side),
    .quo_valid(m_v), .quo(m_q), .quo_side(m_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kappa_value <= m_side.err ? ONE_Q16 : m_side.kappa;
      decay_coef  <= m_side.err ? HALF_Q31 : m_side.b;
      conv_coef   <= (m_side.err || !m_side.signz) ? 32'sd0 : signed'(32'd0 - m_q);
      index_error <= m_side.err;
    end
  end

`ifndef SYNTHESIS
  ap_err_defaults: assert property (@(posedge clk) disable iff (rst)
    result_valid && index_error |->
      kappa_value == ONE_Q16 && decay_coef == HALF_Q31 && conv_coef == 32'sd0)
    else $error("out-of-grid beat carries non-interior coefficients");

  ap_decay_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> decay_coef <= HALF_Q31)
    else $error("decay coefficient above one");

  ap_conv_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (conv_coef[31] || conv_coef == 32'sd0))
    else $error("convolution coefficient positive");

  ap_kappa_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> kappa_value >= ONE_Q16)
    else $error("kappa below one");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ccg_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               axis = 1'b0;
  logic [11:0]        cell_index = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [31:0]        kappa_value;
  logic [31:0]        decay_coef;
  logic signed [31:0] conv_coef;
  logic               index_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  localparam int LATENCY = 206;

  cpml_coefficient_generator_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] kappa;
    logic [31:0] decay;
    logic [31:0] conv;
    logic        err;
  } coef_t;

  // shadow copy of the configuration registers
  logic [12:0] m_width, m_height, m_thick;
  logic [31:0] m_sigma, m_kappa, m_alpha, m_dt;

  coef_t coef_q[$];
  int    n_fail = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_phases = 0;
  bit    stall_on = 1'b1;

  function automatic logic [63:0] fixdiv(logic [63:0] a, logic [63:0] b, int f);
    logic [63:0] q, r;
    q = a / b;
    r = a % b;
    for (int k = 0; k < f; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] k, r, term, pos, neg, e;
    k = x / 64'(LN2_Q32);
    if (k >= 32) return 64'd0;
    r = x - k * 64'(LN2_Q32);
    term = 64'd1 << 32;
    pos = term;
    neg = 0;
    for (int m = 1; m <= 16; m++) begin
      term = ((term * r) >> 32) / m;
      if (m % 2 == 1) neg += term;
      else pos += term;
    end
    e = pos - neg;
    if (e > (64'd1 << 32)) e = 64'd1 << 32;
    return e >> (k + 1);
  endfunction

  function automatic coef_t cell_coefs(logic ax, logic [11:0] ci);
    coef_t o;
    logic [63:0] n, t, idx, num, sigma, alpha, kappa, p, kp, q, x, b, c, s, u, w, m;
    n = ax ? m_height : m_width;
    t = m_thick;
    idx = ci;
    num = 0; sigma = 0; alpha = 0; kappa = ONE_Q16; c = 0;
    o = '{ONE_Q16, HALF_Q31, 32'd0, 1'b0};
    if (n > MAX_DIM) n = MAX_DIM;
    if (idx >= n) begin
      o.err = 1'b1;
      return o;
    end
    if (idx < t) num = t - idx;
    else if (idx + t >= n) num = idx + t + 1 - n;
    if (num != 0) begin
      p = fixdiv(num * num * num, t * t * t, 32);
      kp = (m_kappa < ONE_Q16) ? 64'(ONE_Q16) : 64'(m_kappa);
      sigma = (64'(m_sigma) * p) >> 32;
      alpha = (64'(m_alpha) * p) >> 32;
      kappa = ONE_Q16 + (((kp - ONE_Q16) * p) >> 32);
    end
    q = fixdiv(sigma, kappa, 32) + (alpha << 16);
    x = (q >> 32) * m_dt + (((q & 64'hFFFF_FFFF) * m_dt) >> 32);
    b = exp_neg(x);
    if (sigma != 0) begin
      s = sigma + ((alpha * kappa) >> 16);
      u = fixdiv(sigma, s, 32);
      w = (u * ((64'd1 << 31) - b)) >> 32;
      m = (w << 16) / kappa;
      c = (64'd0 - m) & 64'hFFFF_FFFF;
    end
    o.kappa = kappa[31:0];
    o.decay = b[31:0];
    o.conv = c[31:0];
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stall, check at rising edge
  always @(posedge clk) begin
    coef_t exp_c;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (coef_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        exp_c = coef_q.pop_front();
        if (kappa_value !== exp_c.kappa) begin
          $error("kappa_value exp %h got %h", exp_c.kappa, kappa_value); n_fail++;
        end
        if (decay_coef !== exp_c.decay) begin
          $error("decay_coef exp %h got %h", exp_c.decay, decay_coef); n_fail++;
        end
        if (conv_coef !== exp_c.conv) begin
          $error("conv_coef exp %h got %h", exp_c.conv, conv_coef); n_fail++;
        end
        if (index_error !== exp_c.err) begin
          $error("index_error exp %b got %b", exp_c.err, index_error); n_fail++;
        end
      end
    end
  end

  int stall_cnt = 0;
  always @(negedge clk) begin
    if (!stall_on) result_stall <= 1'b0;
    else if (stall_cnt > 0) begin
      stall_cnt--;
      result_stall <= 1'b1;
    end else begin
      stall_cnt = gap_len();
      result_stall <= (stall_cnt > 0);
      if (stall_cnt > 0) stall_cnt--;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:      m_width = val[12:0];
      REG_GRID_HEIGHT:     m_height = val[12:0];
      REG_LAYER_THICKNESS: m_thick = val[12:0];
      REG_SIGMA_PEAK:      m_sigma = val;
      REG_KAPPA_PEAK:      m_kappa = val;
      REG_ALPHA_PEAK:      m_alpha = val;
      REG_TIME_STEP:       m_dt = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one item beat; valid stays high across back-to-back beats
  task automatic send_cell(logic ax, logic [11:0] ci, bit chk, coef_t want);
    coef_t pred;
    int g;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    item_valid <= 1'b1;
    axis <= ax;
    cell_index <= ci;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = cell_coefs(ax, ci);
    if (chk && pred !== want) begin
      $error("table row %0d/%0d: exp %h got %h", ax, ci, want, pred);
      n_fail++;
    end
    coef_q.push_back(pred);
    n_items++;
    @(negedge clk);
  endtask

  // entered at a falling edge, right after the last accepted beat
  task automatic drain();
    item_valid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
    n_phases++;
  endtask

  typedef struct {
    logic        ax;
    logic [11:0] ci;
    bit          chk;
    coef_t       want;
  } row_t;

  localparam coef_t OUTSIDE = '{ONE_Q16, HALF_Q31, 32'd0, 1'b1};
  localparam coef_t INTERIOR = '{ONE_Q16, HALF_Q31, 32'd0, 1'b0};

  row_t rows[] = '{
    '{1'b0, 12'd0,    1'b0, INTERIOR},
    '{1'b0, 12'd9,    1'b0, INTERIOR},
    '{1'b0, 12'd10,   1'b0, INTERIOR},
    '{1'b0, 12'd128,  1'b1, INTERIOR},
    '{1'b0, 12'd245,  1'b1, INTERIOR},
    '{1'b0, 12'd246,  1'b0, INTERIOR},
    '{1'b0, 12'd255,  1'b0, INTERIOR},
    '{1'b0, 12'd256,  1'b1, OUTSIDE},
    '{1'b0, 12'd4095, 1'b1, OUTSIDE},
    '{1'b1, 12'd0,    1'b0, INTERIOR},
    '{1'b1, 12'd100,  1'b1, INTERIOR},
    '{1'b1, 12'd255,  1'b0, INTERIOR},
    '{1'b1, 12'd300,  1'b1, OUTSIDE},
    '{1'b1, 12'd4095, 1'b1, OUTSIDE}
  };

  task automatic rand_phase(int cnt);
    logic [12:0] n;
    logic        ax;
    int          r;
    for (int k = 0; k < cnt; k++) begin
      ax = $urandom_range(0, 1);
      n = ax ? m_height : m_width;
      r = $urandom_range(0, 9);
      // mostly near the edges where grading happens
      if (r < 4 && n > 0)
        send_cell(ax, 12'($urandom_range(0, (m_thick < n ? m_thick : n))), 0, INTERIOR);
      else if (r < 8 && n > 0)
        send_cell(ax, 12'(n - 1 - $urandom_range(0, m_thick < n ? m_thick : n - 1)), 0, INTERIOR);
      else send_cell(ax, 12'($urandom), 0, INTERIOR);
    end
  endtask

  initial begin
    m_width = 256; m_height = 256; m_thick = 10;
    m_sigma = 65536; m_kappa = 65536; m_alpha = 0; m_dt = 32'h8000_0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_cell(rows[i].ax, rows[i].ci, rows[i].chk, rows[i].want);
    drain();

    // extremes: full-size grid, thick layer, max peaks and time step
    write_reg(REG_GRID_WIDTH, 32'd4096);
    write_reg(REG_GRID_HEIGHT, 32'd8191);
    write_reg(REG_LAYER_THICKNESS, 32'd4096);
    write_reg(REG_SIGMA_PEAK, 32'hFFFF_FFFF);
    write_reg(REG_KAPPA_PEAK, 32'hFFFF_FFFF);
    write_reg(REG_ALPHA_PEAK, 32'hFFFF_FFFF);
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    send_cell(1'b0, 12'd0, 0, INTERIOR);
    send_cell(1'b0, 12'd4095, 0, INTERIOR);
    send_cell(1'b1, 12'd2048, 0, INTERIOR);
    rand_phase(150);
    drain();

    // zero size, zero thickness, kappa peak below one, zero step
    write_reg(REG_GRID_WIDTH, 32'd0);
    write_reg(REG_GRID_HEIGHT, 32'd1);
    write_reg(REG_LAYER_THICKNESS, 32'd0);
    write_reg(REG_KAPPA_PEAK, 32'd0);
    write_reg(REG_SIGMA_PEAK, 32'd0);
    write_reg(REG_ALPHA_PEAK, 32'd0);
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(3'd7, 32'hDEAD_BEEF);
    send_cell(1'b0, 12'd0, 1, OUTSIDE);
    send_cell(1'b1, 12'd0, 1, INTERIOR);
    send_cell(1'b1, 12'd1, 1, OUTSIDE);
    rand_phase(40);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GRID_WIDTH, $urandom_range(1, 4096));
      write_reg(REG_GRID_HEIGHT, $urandom_range(1, 4096));
      write_reg(REG_LAYER_THICKNESS, ph == 0 ? 32'd1 : $urandom_range(0, 64));
      write_reg(REG_SIGMA_PEAK, $urandom);
      write_reg(REG_KAPPA_PEAK, $urandom_range(0, 9) < 3 ? $urandom_range(0, 65535) : $urandom);
      write_reg(REG_ALPHA_PEAK, $urandom_range(0, 3) == 0 ? 32'd0 : $urandom);
      write_reg(REG_TIME_STEP, $urandom);
      stall_on = (ph != 3);
      rand_phase(170);
      drain();
    end

    $display("Ran %0d cell beats over %0d register settings, %0d results checked.",
             n_items, n_phases, n_results);
    if (n_fail == 0) $display("cpml_coefficient_generator_unit: match");
    else $display("cpml_coefficient_generator_unit: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("cpml_coefficient_generator_unit: mismatch");
    $finish;
  end

endmodule
